// ===== rtl/core/mtwd_pkg.sv =====
`default_nettype none
package mtwd_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES = 8;
  localparam int ENTRY_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

  // Field widths of the beats.
  localparam int ACTION_W  = 2;
  localparam int WORD_W    = 32;
  localparam int RATE_W    = 17;
  localparam int SLOT_W    = 3;
  localparam int MASK_W    = 8;
  localparam int CNTOUT_W  = 4;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

  // Millisecond to tick conversion. A division by 1000 is a reciprocal multiply:
  // (x * RECIP_MAGIC) >> RECIP_SHIFT equals x / 1000 for every 32-bit x.
  localparam int                MS_PER_S    = 1000;
  localparam int                REM_W       = $clog2(MS_PER_S);
  localparam logic [WORD_W-1:0] RECIP_MAGIC = 32'h1062_4DD3;
  localparam int                RECIP_SHIFT = 38;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REGISTER = 2'd0,
    ACT_FEED     = 2'd1,
    ACT_CHECK    = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  // One memory word holds a whole table entry.
  typedef struct packed {
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] timeout;
    logic [WORD_W-1:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] ticks;
  } conv_status_t;

  typedef struct packed {
    logic                accepted;
    logic [SLOT_W-1:0]   slot;
    logic                found;
    logic [MASK_W-1:0]   expired_mask;
    logic                all_ok;
    logic [CNTOUT_W-1:0] entry_count;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/mtwd_in_if.sv =====
`default_nettype none
interface mtwd_in_if;
  import mtwd_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [WORD_W-1:0]   task_id;
  logic [WORD_W-1:0]   limit_ms;
  logic [WORD_W-1:0]   now_tick;

  modport source (output valid, action, task_id, limit_ms, now_tick, input ready);
  modport sink   (input valid, action, task_id, limit_ms, now_tick, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mtwd_out_if.sv =====
`default_nettype none
interface mtwd_out_if;
  import mtwd_pkg::*;

  logic                valid;
  logic                ready;
  logic                accepted;
  logic [SLOT_W-1:0]   slot;
  logic                found;
  logic [MASK_W-1:0]   expired_mask;
  logic                all_ok;
  logic [CNTOUT_W-1:0] entry_count;

  modport source (output valid, accepted, slot, found, expired_mask, all_ok, entry_count,
                  input ready);
  modport sink   (input valid, accepted, slot, found, expired_mask, all_ok, entry_count,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mtwd_tick_conv.sv =====
`default_nettype none
module mtwd_tick_conv (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mtwd_pkg::WORD_W-1:0]   ms_i,
  input  wire logic [mtwd_pkg::RATE_W-1:0]   rate_i,
  output mtwd_pkg::conv_status_t             status_o
);
  import mtwd_pkg::*;

  // With ms = 1000 * sec + rem, the tick count is sec * rate + (rem * rate) / 1000.
  // Both divisions by 1000 share one reciprocal multiplier, used at the start
  // and again in the fraction step.
  localparam logic [2:0] STEP_SPLIT = 3'd4;
  localparam logic [2:0] STEP_PART  = 3'd3;
  localparam logic [2:0] STEP_FRAC  = 3'd2;
  localparam logic [2:0] STEP_SUM   = 3'd1;

  logic [WORD_W-1:0]   ms_q;
  logic [RATE_W-1:0]   rate_q;
  logic [WORD_W-1:0]   sec_q;
  logic [REM_W-1:0]    rem_q;
  logic [WORD_W-1:0]   whole_q;
  logic [WORD_W-1:0]   part_q;
  logic [WORD_W-1:0]   frac_q;
  logic [WORD_W-1:0]   ticks_q;
  logic [2:0]          step_q;
  logic                done_q;

  logic [WORD_W-1:0]   recip_in;
  logic [2*WORD_W-1:0] recip_prod;
  logic [WORD_W-1:0]   recip_quot;

  assign recip_in   = start_i ? ms_i : part_q;
  assign recip_prod = (2*WORD_W)'(recip_in) * (2*WORD_W)'(RECIP_MAGIC);
  assign recip_quot = WORD_W'(recip_prod >> RECIP_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (step_q == STEP_SUM);
      if (start_i) begin
        step_q <= STEP_SPLIT;
      end else if (step_q != '0) begin
        step_q <= step_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ms_q   <= ms_i;
      rate_q <= rate_i;
      sec_q  <= recip_quot;
    end else begin
      case (step_q)
        STEP_SPLIT: begin
          rem_q   <= REM_W'(ms_q - sec_q * WORD_W'(MS_PER_S));
          whole_q <= sec_q * WORD_W'(rate_q);
        end
        STEP_PART: begin
          part_q <= WORD_W'(rem_q) * WORD_W'(rate_q);
        end
        STEP_FRAC: begin
          frac_q <= recip_quot;
        end
        STEP_SUM: begin
          ticks_q <= whole_q + frac_q;
        end
        default: begin
        end
      endcase
    end
  end

  // The sums wrap at 32 bits, which is the required truncation.
  assign status_o.done  = done_q;
  assign status_o.ticks = ticks_q;

endmodule
`default_nettype wire

// ===== rtl/core/multi_task_watchdog_table.sv =====
`default_nettype none
// Channel    Dir  Beat contents                                   Handshake
// item_i     in   action, task_id, limit_ms, now_tick             valid/ready
// result_o   out  accepted, slot, found, expired_mask, all_ok,    valid/ready
//                 entry_count
// cfg        in   cfg_wdata_i = tick_rate_hz                      cfg_we_i, no wait
//
// One item is worked on at a time. A feed or check beat visits the table entries in
// turn through the single read port of the entry memory. A register beat that stores
// an entry runs through the tick converter: a launch cycle, four converter steps
// (split, part, fraction, sum), the write-back cycle, the result cycle and the idle
// cycle. Other beats go from the item straight to the result and back to idle.
// Reset empties the table at once, with no clearing pass, and restores the tick rate
// to 1000 Hz. A result waiting on a stalled result_o holds its register while the
// next item is already taken and worked on.
module multi_task_watchdog_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mtwd_in_if.sink                            item_i,
  mtwd_out_if.source                         result_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mtwd_pkg::RATE_W-1:0]   cfg_wdata_i
);
  import mtwd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CONV = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Entry memory: one synchronous write port, one registered read port.
  entry_t mem [MAX_ENTRIES];
  entry_t rd_q;
  logic [ENTRY_W-1:0] rd_addr;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_addr;
  entry_t             wr_data;

  logic [1:0]          state_q, state_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [RATE_W-1:0]   rate_q;
  logic [ENTRY_W-1:0]  idx_q, idx_d;
  action_e             act_q;
  logic [WORD_W-1:0]   id_q, tmo_q, now_q;
  result_t             pend_q, pend_d;
  logic                ok_q, ok_d;
  logic [MASK_W-1:0]   mask_q, mask_d;
  result_t             res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;
  logic                conv_start;
  conv_status_t        conv_st;
  logic                last_entry;
  logic                expired;
  logic [WORD_W-1:0]   elapsed;

  mtwd_tick_conv u_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .ms_i     (tmo_q),
    .rate_i   (rate_q),
    .status_o (conv_st)
  );

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;

  assign rd_addr    = (state_q == ST_SCAN) ? idx_q + ENTRY_W'(1) : '0;
  assign last_entry = ((COUNT_W'(idx_q) + COUNT_W'(1)) == count_q);
  assign elapsed    = now_q - rd_q.last_seen;
  assign expired    = (elapsed > rd_q.timeout);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    ok_d        = ok_q;
    mask_d      = mask_q;
    conv_start  = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = '{id: id_q, timeout: rd_q.timeout, last_seen: now_q};
    out_valid_d = out_valid_q && !result_o.ready;
    res_d             = pend_q;
    res_d.entry_count = CNTOUT_W'(count_q);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pend_d = '0;
          idx_d  = '0;
          // For a register beat ok_q marks that the multiply is not launched yet.
          ok_d   = (action_e'(item_i.action) != ACT_REGISTER);
          mask_d = '0;
          case (action_e'(item_i.action))
            ACT_REGISTER: begin
              if ((item_i.task_id != '0) && (count_q < COUNT_W'(MAX_ENTRIES))) begin
                state_d = ST_CONV;
              end else begin
                state_d = ST_DONE;
              end
            end
            ACT_FEED, ACT_CHECK: begin
              if (count_q == '0) begin
                pend_d.all_ok = (action_e'(item_i.action) == ACT_CHECK);
                state_d       = ST_DONE;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_CONV: begin
        // The first cycle here launches the multiply from the captured item.
        conv_start = !conv_st.done && (idx_q == '0) && !ok_q;
        if (conv_st.done) begin
          wr_en           = 1'b1;
          wr_addr         = ENTRY_W'(count_q);
          wr_data         = '{id: id_q, timeout: conv_st.ticks, last_seen: now_q};
          count_d         = count_q + COUNT_W'(1);
          pend_d.accepted = 1'b1;
          pend_d.slot     = SLOT_W'(count_q);
          state_d         = ST_DONE;
        end
        ok_d = 1'b1;
      end

      ST_SCAN: begin
        if (act_q == ACT_FEED) begin
          if (rd_q.id == id_q) begin
            wr_en        = 1'b1;
            pend_d.found = 1'b1;
            pend_d.slot  = SLOT_W'(idx_q);
            state_d      = ST_DONE;
          end else if (last_entry) begin
            state_d = ST_DONE;
          end
        end else begin
          if (expired) begin
            ok_d   = 1'b0;
            mask_d = mask_q | (MASK_W'(1) << idx_q);
          end
          if (last_entry) begin
            pend_d.all_ok       = ok_d;
            pend_d.expired_mask = mask_d;
            state_d             = ST_DONE;
          end
        end
        idx_d = idx_q + ENTRY_W'(1);
      end

      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rate_q      <= RATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pend_q <= pend_d;
    mask_q <= mask_d;
    ok_q   <= ok_d;
    if (accept) begin
      act_q <= action_e'(item_i.action);
      id_q  <= item_i.task_id;
      tmo_q <= item_i.limit_ms;
      now_q <= item_i.now_tick;
    end
    if ((state_q == ST_DONE) && (!out_valid_q || result_o.ready)) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.accepted     = res_q.accepted;
  assign result_o.slot         = res_q.slot;
  assign result_o.found        = res_q.found;
  assign result_o.expired_mask = res_q.expired_mask;
  assign result_o.all_ok       = res_q.all_ok;
  assign result_o.entry_count  = res_q.entry_count;

endmodule
`default_nettype wire
